/* rtl/afs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the animation frame sequencer: field widths,
// configuration register indexes and play mode codes. No dependencies.
package afs_pkg;

  localparam int MAX_FRAMES  = 256;
  localparam int US_PER_MS   = 1000;

  localparam int ACC_W       = 32;
  localparam int ELAPSED_W   = 20;
  localparam int INTERVAL_W  = 16;
  localparam int COUNT_W     = 9;
  localparam int MODE_W      = 2;
  localparam int FRAME_W     = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_BACK = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD       = 3'd4;

  // play modes; the unused code behaves as play once
  localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd2;

  typedef logic [ACC_W-1:0] word_t;

endpackage

/* rtl/animation_frame_sequencer_core.sv */
`timescale 1ns / 1ps
// Animation frame sequencer: time accumulator, frame stepping for loop,
// ping-pong and play-once modes, one shared restoring divider.
// Depends on afs_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | tvalid/tready      | tuser: action; tdata: elapsed_us
//  out_    | master    | tvalid/tready      | tuser: fired; tdata: frame, backward
//  cfg_    | write     | cfg_we             | cfg_addr, cfg_wdata
//
// Restart, held ticks and ticks not above the interval go from S_SETUP
// straight to S_DONE. A firing tick runs the divider once (S_DIV1) to split
// the accumulator into frames and remainder; play once then goes through S_ADV
// and S_FIN, ping-pong over one frame through S_ADV only. Loop and ping-pong
// run it a second time (S_DIV2) for the advance modulo the cycle, then S_FIN.
// One item at a time; in_tready is low from acceptance until the result is
// moved to the output register, which a stalled sink holds.
// Reset is synchronous, active low, and loads the register defaults.
module animation_frame_sequencer_core
  import afs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [19:0] elapsed_us
  input  logic                   in_tuser,   // [0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] frame_index, [8] backward
  output logic                   out_tuser,  // [0] fired
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_ADV   = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int STEP_W = $clog2(ACC_W);
  localparam int IVUS_W = INTERVAL_W + 10;
  localparam int WIDE_W = COUNT_W + 2;

  // configuration
  logic [INTERVAL_W-1:0] interval_r;
  logic [COUNT_W-1:0]    count_r;
  logic [MODE_W-1:0]     mode_r;
  logic                  start_back_r;
  logic                  hold_r;

  // architectural state
  word_t                 acc_r;
  logic [FRAME_W-1:0]    frame_r;
  logic                  dir_r;

  // sequencer and working registers
  logic [2:0]            state_r;
  logic                  action_r;
  word_t                 sum_r;
  logic [IVUS_W-1:0]     ivus_r;
  word_t                 frames_r;
  logic [COUNT_W-1:0]    cur_r;
  logic                  fired_r;
  logic [STEP_W-1:0]     step_r;

  // shared divider
  word_t                 quo_r;
  word_t                 rem_r;
  word_t                 dvs_r;
  logic [ACC_W:0]        trial;
  logic [ACC_W:0]        diff;
  logic                  ge;

  // output register
  logic                  out_valid_r;
  logic                  out_fired_r;
  logic [FRAME_W-1:0]    out_frame_r;
  logic                  out_back_r;

  logic                  in_acc;
  logic [ACC_W:0]        sum_full;
  word_t                 sum_sat;
  logic [INTERVAL_W-1:0] iv_eff;
  logic [COUNT_W-1:0]    n_eff;
  logic [COUNT_W:0]      p_len;
  logic [COUNT_W-1:0]    cur_clamp;
  logic [ACC_W:0]        once_fwd;
  logic [COUNT_W-1:0]    once_cur;
  logic [WIDE_W-1:0]     loop_t;
  logic [COUNT_W-1:0]    loop_cur;
  logic [WIDE_W-1:0]     pp_u0;
  logic [WIDE_W-1:0]     pp_us;
  logic [WIDE_W-1:0]     pp_u;
  logic [WIDE_W-1:0]     pp_cur;
  logic                  pp_dir;
  logic [WIDE_W-1:0]     rem_k;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fired_r;
  assign out_tdata  = {{(OUT_TDATA_W-FRAME_W-1){1'b0}}, out_back_r, out_frame_r};

  assign sum_full = {1'b0, acc_r} + (ACC_W+1)'(in_tdata[ELAPSED_W-1:0]);
  assign sum_sat  = sum_full[ACC_W] ? {ACC_W{1'b1}} : sum_full[ACC_W-1:0];
  assign iv_eff   = (interval_r == '0) ? INTERVAL_W'(1) : interval_r;

  always_comb begin
    if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_r > COUNT_W'(MAX_FRAMES)) begin
      n_eff = COUNT_W'(MAX_FRAMES);
    end else begin
      n_eff = count_r;
    end
  end

  assign p_len     = {n_eff - COUNT_W'(1), 1'b0};
  assign cur_clamp = ({1'b0, frame_r} >= n_eff) ? n_eff - COUNT_W'(1) : {1'b0, frame_r};

  // divider step: shift in the next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  // play once: clamp at the end it runs into
  assign once_fwd = (ACC_W+1)'(cur_clamp) + {1'b0, frames_r};
  always_comb begin
    if (dir_r) begin
      once_cur = (word_t'(cur_clamp) < frames_r) ? '0
                 : cur_clamp - COUNT_W'(frames_r);
    end else begin
      once_cur = (once_fwd >= (ACC_W+1)'(n_eff)) ? n_eff - COUNT_W'(1)
                 : COUNT_W'(once_fwd);
    end
  end

  // loop and ping-pong, advance reduced by the divider
  assign rem_k = WIDE_W'(rem_r[COUNT_W:0]);
  always_comb begin
    if (dir_r) begin
      loop_t = WIDE_W'(cur_r) + WIDE_W'(n_eff) - rem_k;
    end else begin
      loop_t = WIDE_W'(cur_r) + rem_k;
    end
    loop_cur = (loop_t >= WIDE_W'(n_eff)) ? COUNT_W'(loop_t - WIDE_W'(n_eff))
               : COUNT_W'(loop_t);

    if (dir_r && (cur_r != '0)) begin
      pp_u0 = WIDE_W'(p_len) - WIDE_W'(cur_r);
    end else if (dir_r) begin
      pp_u0 = '0;
    end else begin
      pp_u0 = WIDE_W'(cur_r);
    end
    pp_us  = pp_u0 + rem_k;
    pp_u   = (pp_us >= WIDE_W'(p_len)) ? pp_us - WIDE_W'(p_len) : pp_us;
    pp_cur = (pp_u < WIDE_W'(n_eff)) ? pp_u : WIDE_W'(p_len) - pp_u;
    pp_dir = (pp_u >= WIDE_W'(n_eff)) || (pp_u == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_W'(100);
      count_r      <= COUNT_W'(1);
      mode_r       <= MODE_LOOP;
      start_back_r <= 1'b0;
      hold_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INTERVAL:   interval_r   <= cfg_wdata[INTERVAL_W-1:0];
        REG_COUNT:      count_r      <= cfg_wdata[COUNT_W-1:0];
        REG_MODE:       mode_r       <= cfg_wdata[MODE_W-1:0];
        REG_START_BACK: start_back_r <= cfg_wdata[0];
        REG_HOLD:       hold_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      frame_r     <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            action_r <= in_tuser;
            sum_r    <= sum_sat;
            ivus_r   <= IVUS_W'(iv_eff) * IVUS_W'(US_PER_MS);
            state_r  <= S_SETUP;
          end
        end
        S_SETUP: begin
          fired_r <= 1'b0;
          state_r <= S_DONE;
          if (action_r) begin
            acc_r   <= '0;
            frame_r <= '0;
            dir_r   <= start_back_r;
          end else if (!hold_r) begin
            if (sum_r > word_t'(ivus_r)) begin
              quo_r   <= sum_r;
              rem_r   <= '0;
              dvs_r   <= word_t'(ivus_r);
              step_r  <= '1;
              state_r <= S_DIV1;
            end else begin
              acc_r <= sum_r;
            end
          end
        end
        S_DIV1, S_DIV2: begin
          quo_r  <= {quo_r[ACC_W-2:0], ge};
          rem_r  <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            state_r <= (state_r == S_DIV1) ? S_ADV : S_FIN;
          end
        end
        S_ADV: begin
          acc_r    <= rem_r;
          frames_r <= quo_r;
          fired_r  <= 1'b1;
          cur_r    <= cur_clamp;
          quo_r    <= quo_r;
          rem_r    <= '0;
          step_r   <= '1;
          if (mode_r == MODE_LOOP) begin
            dvs_r   <= word_t'(n_eff);
            state_r <= S_DIV2;
          end else if (mode_r == MODE_PINGPONG && n_eff != COUNT_W'(1)) begin
            dvs_r   <= word_t'(p_len);
            state_r <= S_DIV2;
          end else if (mode_r == MODE_PINGPONG) begin
            frame_r <= '0;
            state_r <= S_DONE;
          end else begin
            // play once needs the raw advance; frames_r is loaded this cycle
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_DONE;
          if (mode_r == MODE_LOOP) begin
            frame_r <= FRAME_W'(loop_cur);
          end else if (mode_r == MODE_PINGPONG) begin
            // a zero reduced advance keeps frame and direction
            frame_r <= (rem_k != '0) ? FRAME_W'(pp_cur) : FRAME_W'(cur_r);
            if (rem_k != '0) begin
              dir_r <= pp_dir;
            end
          end else begin
            frame_r <= FRAME_W'(once_cur);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_fired_r <= fired_r;
            out_frame_r <= frame_r;
            out_back_r  <= dir_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the partial remainder never reaches the divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // an accepted item always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SETUP && !in_tready))
    else $error("sequencer did not leave idle after accept");

  // a result is only loaded from the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE && state_r == S_IDLE))
    else $error("result loaded outside the final state");

  // a firing item has always gone through the divider
  a_fired_divided: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && fired_r) |-> (acc_r < dvs_r || mode_r != MODE_LOOP
                                         || dvs_r == word_t'(n_eff)))
    else $error("fired result without a division");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for animation_frame_sequencer_core: directed corner cases first, then
// randomised phases of ticks and restarts under changing register settings and back-pressure.
// Depends on afs_pkg and the core RTL.
module tb_top;
  import afs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 46;
  localparam int LONG_PHASE   = 5;
  localparam int LONG_ITEMS   = 130;
  localparam int PAUSE_PHASE  = 8;

  localparam logic [ELAPSED_W-1:0] US_MAX = '1;
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  // spare mode code, expected to behave as play once
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic               fired;
    logic [FRAME_W-1:0] frame;
    logic               backward;
  } frame_result_t;

  class frame_scoreboard;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [COUNT_W-1:0]    frame_count;
    logic [MODE_W-1:0]     play_mode;
    logic                  start_back;
    logic                  hold_on;
    logic [ACC_W-1:0]      acc_us;
    logic [FRAME_W-1:0]    frame;
    logic                  rev;
    frame_result_t         pending_frames[$];
    int items, restarts, held_ticks, results, fired_count, errors;

    function new();
      interval_ms = 16'd100;
      frame_count = 9'd1;
      play_mode   = MODE_LOOP;
      start_back  = 1'b0;
      hold_on     = 1'b0;
      acc_us      = '0;
      frame       = '0;
      rev         = 1'b0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_INTERVAL:   interval_ms = val[INTERVAL_W-1:0];
        REG_COUNT:      frame_count = val[COUNT_W-1:0];
        REG_MODE:       play_mode = val[MODE_W-1:0];
        REG_START_BACK: start_back = val[0];
        REG_HOLD:       hold_on = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    // move the frame by k steps according to the play mode
    function void step_frames(logic [31:0] k);
      int unsigned n, cur, kk, p, u;
      n = (frame_count == 0) ? 32'd1 : 32'(frame_count);
      if (n > MAX_FRAMES) n = MAX_FRAMES;
      cur = 32'(frame);
      if (cur >= n) cur = n - 1;
      if (play_mode == MODE_LOOP) begin
        kk = k % n;
        cur = rev ? (cur + n - kk) % n : (cur + kk) % n;
      end else if (play_mode == MODE_PINGPONG) begin
        if (n == 1) begin
          cur = 0;
        end else begin
          // unfold the bounce into a cycle of 2*(n-1) positions
          p = 2 * (n - 1);
          kk = k % p;
          if (kk != 0) begin
            u = rev ? (p - cur) % p : cur;
            u = (u + kk) % p;
            cur = (u < n) ? u : p - u;
            rev = (u >= n) || (u == 0);
          end
        end
      end else if (rev) begin
        cur = (cur < k) ? 0 : cur - k;
      end else begin
        cur = (cur + k >= n) ? n - 1 : cur + k;
      end
      frame = cur[FRAME_W-1:0];
    endfunction

    function void note_tick(logic act, logic [ELAPSED_W-1:0] us);
      logic [63:0] acc_sum, iv_us, frames;
      frame_result_t want;
      want.fired = 1'b0;
      items++;
      if (act == ACT_RESTART) begin
        acc_us = '0;
        frame = '0;
        rev = start_back;
        restarts++;
      end else if (hold_on) begin
        held_ticks++;
      end else begin
        acc_sum = {32'd0, acc_us} + {44'd0, us};
        if (acc_sum > 64'hFFFF_FFFF) acc_sum = 64'hFFFF_FFFF;
        iv_us = (interval_ms == 0) ? 64'd1000 : {48'd0, interval_ms} * 64'd1000;
        if (acc_sum > iv_us) begin
          frames = (acc_sum / 64'd1000) / (iv_us / 64'd1000);
          acc_sum = acc_sum - frames * iv_us;
          want.fired = 1'b1;
          step_frames(frames[31:0]);
        end
        acc_us = acc_sum[ACC_W-1:0];
      end
      want.frame = frame;
      want.backward = rev;
      pending_frames.push_back(want);
    endfunction

    function void check_frame(logic fired, logic [FRAME_W-1:0] fr, logic back);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result fired=%0b frame=%0d backward=%0b",
                   fired, fr, back);
        return;
      end
      want = pending_frames.pop_front();
      results++;
      if (fired === 1'b1) fired_count++;
      if (fired !== want.fired || fr !== want.frame || back !== want.backward) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: expected fired=%0b frame=%0d backward=%0b, %s%0b %s%0d %s%0b",
                   results, want.fired, want.frame, want.backward,
                   "got fired=", fired, "frame=", fr, "backward=", back);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [19:0] elapsed_us
  logic                   in_tuser   = 1'b0;  // [0] action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] frame_index, [8] backward
  logic                   out_tuser;  // [0] fired
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  frame_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int settings      = 0;
  int cycles        = 0;

  animation_frame_sequencer_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame(out_tuser, out_tdata[FRAME_W-1:0], out_tdata[FRAME_W]);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("animation_frame_sequencer_core test failed");
      $finish;
    end
  end

  task automatic push_item(logic act, logic [ELAPSED_W-1:0] us);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'(us);
    do @(posedge clk); while (!in_tready);
    sb.note_tick(act, us);
  endtask

  // drop valid and hold until every outstanding result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(int unsigned iv, int unsigned cnt, logic [MODE_W-1:0] mode,
                               logic back, logic hld);
    settle();
    write_reg(REG_INTERVAL, CFG_DATA_W'(iv));
    write_reg(REG_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_START_BACK, CFG_DATA_W'(back));
    write_reg(REG_HOLD, CFG_DATA_W'(hld));
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_elapsed(int unsigned iv);
    int unsigned span, cap, roll, val, us_top;
    us_top = 32'(US_MAX);
    span = ((iv == 0) ? 1 : iv) * 1000;
    if (span > us_top) span = us_top;
    cap = (2 * span > us_top) ? us_top : 2 * span;
    roll = $urandom_range(0, 99);
    if (roll < 50) val = $urandom_range(0, cap);
    else if (roll < 65) val = $urandom_range(0, span / 1000 + 2) * 1000;  // whole ms
    else if (roll < 80) val = $urandom_range(0, us_top);
    else if (roll < 90) val = $urandom_range(0, 999);
    else begin
      case ($urandom_range(0, 4))
        0: val = 0;
        1: val = us_top;
        2: val = 1000000;
        3: val = span;
        default: val = span + 1;
      endcase
    end
    return (val > us_top) ? US_MAX : val[ELAPSED_W-1:0];
  endfunction

  initial begin
    int unsigned iv, cnt, roll, n_items;
    logic [MODE_W-1:0] mode;
    logic hld;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: 100 ms, one frame, loop
    push_item(ACT_TICK, 20'd0);
    push_item(ACT_TICK, 20'd1000000);
    push_item(ACT_TICK, US_MAX);
    push_item(ACT_RESTART, 20'd0);

    // ping-pong over five frames starting backward: bounces, exact ends, zero advance
    apply_setting(1, 5, MODE_PINGPONG, 1'b1, 1'b0);
    push_item(ACT_RESTART, US_MAX);
    push_item(ACT_TICK, 20'd1500);
    push_item(ACT_TICK, 20'd2500);
    push_item(ACT_TICK, 20'd4000);
    push_item(ACT_TICK, 20'd8000);
    push_item(ACT_TICK, 20'd1000);  // equal to the interval: no advance
    push_item(ACT_TICK, 20'd1);
    push_item(ACT_TICK, 20'd19000);

    // zero interval and ping-pong with a single frame
    apply_setting(0, 1, MODE_PINGPONG, 1'b0, 1'b0);
    push_item(ACT_TICK, 20'd1001);
    push_item(ACT_TICK, 20'd5000);

    // zero frame count
    apply_setting(2, 0, MODE_ONCE, 1'b0, 1'b0);
    push_item(ACT_TICK, 20'd3000);

    apply_setting(1, 10, MODE_LOOP, 1'b0, 1'b0);
    push_item(ACT_RESTART, 20'd0);
    push_item(ACT_TICK, 20'd8500);

    // lower the count below the current frame, spare mode code
    apply_setting(1, 3, MODE_SPARE, 1'b1, 1'b0);
    push_item(ACT_TICK, 20'd1500);
    push_item(ACT_RESTART, 20'd0);
    push_item(ACT_TICK, 20'd2500);

    // count above the frame limit, held; restart still applies
    apply_setting(1, 511, MODE_LOOP, 1'b0, 1'b1);
    push_item(ACT_TICK, 20'd50000);
    push_item(ACT_RESTART, 20'd0);

    apply_setting(1, 256, MODE_ONCE, 1'b0, 1'b0);
    push_item(ACT_TICK, 20'd300000);
    push_item(ACT_TICK, 20'd1000000);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 60) iv = $urandom_range(1, 20);
      else if (roll < 85) iv = $urandom_range(21, 1000);
      else iv = $urandom_range(0, 65535);
      roll = $urandom_range(0, 99);
      if (roll < 60) cnt = $urandom_range(1, 8);
      else if (roll < 85) cnt = $urandom_range(9, 256);
      else cnt = $urandom_range(0, 511);
      mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_W'($urandom_range(0, 2));
      hld = ($urandom_range(0, 5) == 0);
      n_items = PHASE_ITEMS;
      if (ph == LONG_PHASE) begin
        // longest interval, fed with near-maximum ticks so that it fires at all
        iv = 65535;
        cnt = 256;
        hld = 1'b0;
        n_items = LONG_ITEMS;
      end
      apply_setting(iv, cnt, mode, 1'($urandom_range(0, 1)), hld);
      for (int i = 0; i < n_items; i++) begin
        if (ph == PAUSE_PHASE && i == n_items / 2) settle();
        if (ph == LONG_PHASE)
          push_item(ACT_TICK, ELAPSED_W'($urandom_range(900000, 32'(US_MAX))));
        else if ($urandom_range(0, 99) < 8)
          push_item(ACT_RESTART, ELAPSED_W'($urandom_range(0, 32'(US_MAX))));
        else
          push_item(ACT_TICK, pick_elapsed(iv));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d items (%0d restarts, %0d held ticks) under %0d register settings.",
             sb.items, sb.restarts, sb.held_ticks, settings);
    $display("Checked %0d results, %0d of them advancing the frame; %0d errors.",
             sb.results, sb.fired_count, sb.errors);
    if (sb.errors == 0)
      $display("animation_frame_sequencer_core test passed");
    else
      $display("animation_frame_sequencer_core test failed");
    $finish;
  end

endmodule
